### rtl/core/umsr_pkg.sv
package umsr_pkg;

   // Message store geometry
   localparam int STORE_BYTES = 64;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int FILL_W      = $clog2(STORE_BYTES + 1);

   // Smallest stored prefix that an end packet or a single byte may extend
   localparam int MIN_STORED  = 3;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // USB-MIDI code index numbers
   localparam logic [3:0] CODE_SYSEX  = 4'd4;
   localparam logic [3:0] CODE_END1   = 4'd5;
   localparam logic [3:0] CODE_END2   = 4'd6;
   localparam logic [3:0] CODE_END3   = 4'd7;
   localparam logic [3:0] CODE_CC     = 4'd11;
   localparam logic [3:0] CODE_SINGLE = 4'd15;

   // MIDI byte values
   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_END   = 8'hF7;
   localparam logic [3:0] CC_STATUS   = 4'hB;

   typedef enum logic [1:0] {
      KIND_SYSEX    = 2'd0,
      KIND_CC       = 2'd1,
      KIND_INVALID  = 2'd2,
      KIND_OVERFLOW = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_CC       = 2'd0,
      OP_INVALID  = 2'd1,
      OP_OVERFLOW = 2'd2,
      OP_DRAIN    = 2'd3
   } op_type;

   typedef struct packed {
      logic [3:0] code_index;
      logic [7:0] byte_one;
      logic [7:0] byte_two;
      logic [7:0] byte_three;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [6:0] controller_number;
      logic [6:0] controller_value;
      logic       last;
   } rsp_type;

   // Work handed from front to back
   typedef struct packed {
      op_type            op;
      logic [7:0]        status;
      logic [6:0]        number;
      logic [6:0]        value;
      logic [FILL_W-1:0] len;
   } cmd_type;

   // Store write port driven by the front
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } store_wr_type;

endpackage

### rtl/core/usb_midi_sysex_reassembler.sv
// USB-MIDI SysEx reassembler. One word on req_data is one USB-MIDI event
// packet (cable number dropped). SysEx packets are collected in a 64-byte
// store; an end packet or a single 0xF7 byte releases the whole message on
// rsp_data one byte per word, last set on its final byte. Control-change
// packets pass straight through as one word; framing errors and store
// overflow give one error word and empty the store. Sequence: the front
// classifies a packet in ST_EXEC, writes its bytes to the store one per
// ST_WRITE step, then queues any result in ST_PUSH. A completed message is
// read from the store byte by byte (address in BK_READ, then registered read
// data sent in BK_EMIT), and the front holds req_stall until that read-out
// is finished.
// Control-change and error words travel through a four-entry command queue,
// so they do not wait on the front. No clearing pass follows reset.
module usb_midi_sysex_reassembler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  umsr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output umsr_pkg::rsp_type rsp_data
);

   umsr_pkg::store_wr_type store_wr;
   umsr_pkg::cmd_type      push_cmd;
   umsr_pkg::cmd_type      head_cmd;
   logic                   q_push;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_empty;
   logic                   drain_done;

   umsr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .store_wr   (store_wr),
      .q_push     (q_push),
      .q_cmd      (push_cmd),
      .q_full     (q_full),
      .drain_done (drain_done)
   );

   umsr_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (head_cmd)
   );

   umsr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .store_wr   (store_wr),
      .q_empty    (q_empty),
      .q_head     (head_cmd),
      .q_pop      (q_pop),
      .drain_done (drain_done),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

### rtl/core/umsr_cmd_queue.sv
module umsr_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  umsr_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output umsr_pkg::cmd_type head
);

   umsr_pkg::cmd_type               entry_ff [umsr_pkg::QUEUE_DEPTH];
   logic [umsr_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [umsr_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [umsr_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign full    = (count_ff == umsr_pkg::QCNT_W'(umsr_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/core/umsr_front.sv
module umsr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  umsr_pkg::req_type      req_data,
   output umsr_pkg::store_wr_type store_wr,
   output logic                   q_push,
   output umsr_pkg::cmd_type      q_cmd,
   input  logic                   q_full,
   input  logic                   drain_done
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WRITE,
      ST_PUSH
   } state_type;

   localparam logic [umsr_pkg::FILL_W-1:0] FULL_FILL =
      umsr_pkg::FILL_W'(umsr_pkg::STORE_BYTES);
   localparam logic [umsr_pkg::FILL_W-1:0] MIN_FILL =
      umsr_pkg::FILL_W'(umsr_pkg::MIN_STORED);
   localparam logic [umsr_pkg::FILL_W:0]   LIMIT_WIDE =
      (umsr_pkg::FILL_W + 1)'(umsr_pkg::STORE_BYTES);

   state_type                      state_ff, state_in;
   umsr_pkg::req_type              pkt_ff, pkt_in;
   logic [umsr_pkg::FILL_W-1:0]    fill_ff, fill_in;
   logic [7:0]                     first_ff, first_in;
   logic                           pend_ff, pend_in;
   logic [1:0]                     nbytes_ff, nbytes_in;
   logic [1:0]                     widx_ff, widx_in;
   logic                           drain_ff, drain_in;
   umsr_pkg::cmd_type              cmd_ff, cmd_in;

   logic [7:0]                     pb [3];
   logic [1:0]                     end_n;
   logic [7:0]                     close_byte;
   logic [umsr_pkg::FILL_W:0]      end_sum;
   logic [umsr_pkg::FILL_W:0]      sysex_sum;
   logic                           have_prefix;
   logic                           store_full;

   assign pb[0] = pkt_ff.byte_one;
   assign pb[1] = pkt_ff.byte_two;
   assign pb[2] = pkt_ff.byte_three;

   // end packet: byte count and closing byte
   assign end_n       = 2'(pkt_ff.code_index - umsr_pkg::CODE_SYSEX);
   assign close_byte  = pb[end_n - 2'd1];
   assign end_sum     = {1'b0, fill_ff} + (umsr_pkg::FILL_W + 1)'(end_n);
   assign sysex_sum   = {1'b0, fill_ff} + (umsr_pkg::FILL_W + 1)'(3);
   assign have_prefix = (fill_ff >= MIN_FILL);
   assign store_full  = (fill_ff >= FULL_FILL);

   assign req_stall = (state_ff != ST_IDLE) || pend_ff;

   assign store_wr.en   = (state_ff == ST_WRITE);
   assign store_wr.addr = fill_ff[umsr_pkg::ADDR_W-1:0];
   assign store_wr.data = pb[widx_ff];

   assign q_push = (state_ff == ST_PUSH) && !q_full;
   assign q_cmd  = cmd_ff;

   // classify a packet and sequence its store writes
   always_comb begin
      state_in  = state_ff;
      pkt_in    = pkt_ff;
      fill_in   = fill_ff;
      first_in  = first_ff;
      pend_in   = pend_ff;
      nbytes_in = nbytes_ff;
      widx_in   = widx_ff;
      drain_in  = drain_ff;
      cmd_in    = cmd_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               pkt_in   = req_data;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in  = ST_IDLE;
            nbytes_in = 2'd1;
            widx_in   = '0;
            drain_in  = 1'b0;
            cmd_in    = '{op: umsr_pkg::OP_OVERFLOW, status: '0, number: '0,
                          value: '0, len: '0};
            case (pkt_ff.code_index)
               umsr_pkg::CODE_SINGLE: begin
                  if ((pkt_ff.byte_one == umsr_pkg::SYSEX_END) && have_prefix) begin
                     if (store_full) begin
                        fill_in  = '0;
                        state_in = ST_PUSH;
                     end else begin
                        drain_in = 1'b1;
                        state_in = ST_WRITE;
                     end
                  end else if (!pkt_ff.byte_one[7] && have_prefix) begin
                     if (store_full) begin
                        fill_in  = '0;
                        state_in = ST_PUSH;
                     end else begin
                        state_in = ST_WRITE;
                     end
                  end
               end

               umsr_pkg::CODE_END1, umsr_pkg::CODE_END2, umsr_pkg::CODE_END3: begin
                  if (!have_prefix || (first_ff != umsr_pkg::SYSEX_START) ||
                      (close_byte != umsr_pkg::SYSEX_END)) begin
                     cmd_in.op = umsr_pkg::OP_INVALID;
                     fill_in   = '0;
                     state_in  = ST_PUSH;
                  end else if (end_sum > LIMIT_WIDE) begin
                     fill_in  = '0;
                     state_in = ST_PUSH;
                  end else begin
                     nbytes_in = end_n;
                     drain_in  = 1'b1;
                     state_in  = ST_WRITE;
                  end
               end

               umsr_pkg::CODE_SYSEX: begin
                  if (sysex_sum > LIMIT_WIDE) begin
                     fill_in  = '0;
                     state_in = ST_PUSH;
                  end else begin
                     nbytes_in = 2'd3;
                     state_in  = ST_WRITE;
                  end
               end

               umsr_pkg::CODE_CC: begin
                  if (pkt_ff.byte_one[7:4] == umsr_pkg::CC_STATUS) begin
                     cmd_in   = '{op: umsr_pkg::OP_CC, status: pkt_ff.byte_one,
                                  number: pkt_ff.byte_two[6:0],
                                  value: pkt_ff.byte_three[6:0], len: '0};
                     state_in = ST_PUSH;
                  end
               end

               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_WRITE: begin
            fill_in = fill_ff + 1'b1;
            widx_in = widx_ff + 1'b1;
            if (fill_ff == '0) begin
               first_in = pb[widx_ff];
            end
            if (widx_ff == nbytes_ff - 2'd1) begin
               if (drain_ff) begin
                  cmd_in   = '{op: umsr_pkg::OP_DRAIN, status: '0, number: '0,
                               value: '0, len: fill_ff + 1'b1};
                  fill_in  = '0;
                  state_in = ST_PUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_PUSH: begin
            if (!q_full) begin
               state_in = ST_IDLE;
               if (cmd_ff.op == umsr_pkg::OP_DRAIN) begin
                  pend_in = 1'b1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // back has read the whole message: store may be written again
      if (drain_done) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
      end
      pkt_ff    <= pkt_in;
      first_ff  <= first_in;
      nbytes_ff <= nbytes_in;
      widx_ff   <= widx_in;
      drain_ff  <= drain_in;
      cmd_ff    <= cmd_in;
   end

   // fill never passes the store size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_FILL)
      else $error("fill count beyond store size");

   // no store write while the back is draining
   a_no_write_in_drain: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !store_wr.en)
      else $error("store written during drain");

   // a drained message always holds a full prefix plus its closing byte
   a_drain_len: assert property (@(posedge clock) disable iff (reset)
      (q_push && (q_cmd.op == umsr_pkg::OP_DRAIN)) |-> (q_cmd.len > MIN_FILL))
      else $error("drain of a short message");

endmodule

### rtl/core/umsr_back.sv
module umsr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  umsr_pkg::store_wr_type store_wr,
   input  logic                   q_empty,
   input  umsr_pkg::cmd_type      q_head,
   output logic                   q_pop,
   output logic                   drain_done,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output umsr_pkg::rsp_type      rsp_data
);

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_EMIT
   } state_type;

   logic [7:0]                     store_mem [umsr_pkg::STORE_BYTES];
   logic [7:0]                     rd_data_ff;

   state_type                      state_ff, state_in;
   logic [umsr_pkg::ADDR_W-1:0]    idx_ff, idx_in;
   logic [umsr_pkg::FILL_W-1:0]    len_ff, len_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   umsr_pkg::rsp_type              rsp_ff, rsp_in;

   logic                           slot_free;
   logic                           load;
   logic                           is_last;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign is_last   = (({1'b0, idx_ff} + umsr_pkg::FILL_W'(1)) == len_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // message store: written by the front, read here
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[store_wr.addr] <= store_wr.data;
      end
      rd_data_ff <= store_mem[idx_ff];
   end

   // command execution and output register
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      len_in     = len_ff;
      rsp_in     = rsp_ff;
      q_pop      = 1'b0;
      load       = 1'b0;
      drain_done = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               case (q_head.op)
                  umsr_pkg::OP_DRAIN: begin
                     q_pop    = 1'b1;
                     idx_in   = '0;
                     len_in   = q_head.len;
                     state_in = BK_READ;
                  end
                  umsr_pkg::OP_CC: begin
                     if (slot_free) begin
                        q_pop  = 1'b1;
                        load   = 1'b1;
                        rsp_in = '{kind: umsr_pkg::KIND_CC, data_byte: q_head.status,
                                   controller_number: q_head.number,
                                   controller_value: q_head.value, last: 1'b1};
                     end
                  end
                  umsr_pkg::OP_INVALID: begin
                     if (slot_free) begin
                        q_pop  = 1'b1;
                        load   = 1'b1;
                        rsp_in = '{kind: umsr_pkg::KIND_INVALID, data_byte: '0,
                                   controller_number: '0, controller_value: '0,
                                   last: 1'b1};
                     end
                  end
                  default: begin
                     if (slot_free) begin
                        q_pop  = 1'b1;
                        load   = 1'b1;
                        rsp_in = '{kind: umsr_pkg::KIND_OVERFLOW, data_byte: '0,
                                   controller_number: '0, controller_value: '0,
                                   last: 1'b1};
                     end
                  end
               endcase
            end
         end

         // store read data lands in rd_data_ff
         BK_READ: begin
            state_in = BK_EMIT;
         end

         BK_EMIT: begin
            if (slot_free) begin
               load   = 1'b1;
               rsp_in = '{kind: umsr_pkg::KIND_SYSEX, data_byte: rd_data_ff,
                          controller_number: '0, controller_value: '0,
                          last: is_last};
               if (is_last) begin
                  drain_done = 1'b1;
                  state_in   = BK_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = BK_READ;
               end
            end
         end

         default: begin
            state_in = BK_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff <= len_in;
      rsp_ff <= rsp_in;
   end

   // end of a drain shows up as the final byte of a message
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      drain_done |=> (rsp_valid_ff && rsp_ff.last &&
                      (rsp_ff.kind == umsr_pkg::KIND_SYSEX)))
      else $error("drain end without final message byte");

   // commands are taken only between drains
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == BK_IDLE))
      else $error("command popped during a drain");

   // single results always carry the last marker
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.kind != umsr_pkg::KIND_SYSEX)) |-> rsp_ff.last)
      else $error("single result without last marker");

endmodule

### test/tb_usb_midi_sysex_reassembler.sv
module tb_usb_midi_sysex_reassembler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 270;
   localparam int CYCLE_LIMIT  = 4000000;
   localparam int SETTLE_TIME  = 200;
   localparam int MAX_REPORTS  = 10;
   localparam int LONG_TAILS   = 7;

   // One queued input word, optionally held back until the output drains
   typedef struct {
      umsr_pkg::req_type word;
      bit                settle;
   } packet_item_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   umsr_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   umsr_pkg::rsp_type rsp_data;

   usb_midi_sysex_reassembler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   packet_item_type   packet_q[$];
   umsr_pkg::rsp_type awaited_rsp[$];

   // Shadow of the SysEx store
   logic [7:0] msg_bytes [umsr_pkg::STORE_BYTES];
   int         msg_fill;

   logic took_req;
   int   cycle_count;
   int   fail_count;
   int   send_gap;
   int   send_quiet;
   int   stall_left;
   int   stall_quiet;
   bit   settle_next;
   int   live_words;
   int   long_count;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Idle length: mostly short, a few long, with quiet stretches of none
   function automatic int pick_idle(inout int quiet);
      int r;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         quiet = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   function automatic umsr_pkg::rsp_type make_rsp(umsr_pkg::kind_type k, logic [7:0] d,
                                                  logic [6:0] n, logic [6:0] v, logic l);
      umsr_pkg::rsp_type r;
      r.kind              = k;
      r.data_byte         = d;
      r.controller_number = n;
      r.controller_value  = v;
      r.last              = l;
      return r;
   endfunction

   function automatic bit is_live_code(input logic [3:0] c);
      return c == umsr_pkg::CODE_SYSEX || c == umsr_pkg::CODE_END1 ||
             c == umsr_pkg::CODE_END2 || c == umsr_pkg::CODE_END3 ||
             c == umsr_pkg::CODE_CC || c == umsr_pkg::CODE_SINGLE;
   endfunction

   // Error word: one result, store emptied
   task automatic flag_error(input umsr_pkg::kind_type k);
      msg_fill = 0;
      awaited_rsp.push_back(make_rsp(k, 8'h00, 7'h00, 7'h00, 1'b1));
   endtask

   task automatic store_byte(input logic [7:0] b);
      if (msg_fill < umsr_pkg::STORE_BYTES) begin
         msg_bytes[msg_fill] = b;
         msg_fill++;
      end
   endtask

   // Whole message out, last on the final byte
   task automatic release_message();
      for (int i = 0; i < msg_fill; i++)
         awaited_rsp.push_back(make_rsp(umsr_pkg::KIND_SYSEX, msg_bytes[i], 7'h00, 7'h00,
                                        i == msg_fill - 1));
      msg_fill = 0;
   endtask

   // Expected words for one accepted packet
   task automatic predict_packet(input umsr_pkg::req_type w);
      int         nend;
      logic [7:0] closing;
      case (w.code_index)
         umsr_pkg::CODE_SINGLE: begin
            if (w.byte_one == umsr_pkg::SYSEX_END && msg_fill >= umsr_pkg::MIN_STORED) begin
               if (msg_fill >= umsr_pkg::STORE_BYTES) begin
                  flag_error(umsr_pkg::KIND_OVERFLOW);
               end else begin
                  store_byte(w.byte_one);
                  release_message();
               end
            end else if (!w.byte_one[7] && msg_fill >= umsr_pkg::MIN_STORED) begin
               if (msg_fill >= umsr_pkg::STORE_BYTES) flag_error(umsr_pkg::KIND_OVERFLOW);
               else store_byte(w.byte_one);
            end
         end
         umsr_pkg::CODE_END1, umsr_pkg::CODE_END2, umsr_pkg::CODE_END3: begin
            nend = int'(w.code_index) - int'(umsr_pkg::CODE_SYSEX);
            closing = (nend == 1) ? w.byte_one : (nend == 2) ? w.byte_two : w.byte_three;
            if (msg_fill < umsr_pkg::MIN_STORED || msg_bytes[0] != umsr_pkg::SYSEX_START ||
                closing != umsr_pkg::SYSEX_END) begin
               flag_error(umsr_pkg::KIND_INVALID);
            end else if (msg_fill + nend > umsr_pkg::STORE_BYTES) begin
               flag_error(umsr_pkg::KIND_OVERFLOW);
            end else begin
               store_byte(w.byte_one);
               if (nend > 1) store_byte(w.byte_two);
               if (nend > 2) store_byte(w.byte_three);
               release_message();
            end
         end
         umsr_pkg::CODE_SYSEX: begin
            if (msg_fill + 3 > umsr_pkg::STORE_BYTES) begin
               flag_error(umsr_pkg::KIND_OVERFLOW);
            end else begin
               store_byte(w.byte_one);
               store_byte(w.byte_two);
               store_byte(w.byte_three);
            end
         end
         umsr_pkg::CODE_CC: begin
            if (w.byte_one[7:4] == umsr_pkg::CC_STATUS)
               awaited_rsp.push_back(make_rsp(umsr_pkg::KIND_CC, w.byte_one,
                                              w.byte_two[6:0], w.byte_three[6:0], 1'b1));
         end
         default: ;
      endcase
   endtask

   task automatic add_word(input logic [3:0] c, input logic [7:0] b1, input logic [7:0] b2,
                           input logic [7:0] b3);
      packet_item_type it;
      it.word.code_index = c;
      it.word.byte_one   = b1;
      it.word.byte_two   = b2;
      it.word.byte_three = b3;
      it.settle          = settle_next;
      settle_next        = 1'b0;
      packet_q.push_back(it);
      if (is_live_code(c)) live_words++;
   endtask

   function automatic logic [7:0] rnd_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] rnd_data();
      return 8'($urandom_range(0, 127));
   endfunction

   // Random byte that differs from the one given
   function automatic logic [7:0] rnd_other(input logic [7:0] avoid);
      logic [7:0] b;
      b = rnd_byte();
      if (b == avoid) b = ~b;
      return b;
   endfunction

   // Short message with random content; a broken one has one framing fault
   task automatic gen_message(input bit broken);
      int         flaw;
      int         conts;
      int         r;
      logic [7:0] closing;
      logic [7:0] status;
      flaw = broken ? $urandom_range(0, 2) : 3;
      if (flaw == 2) begin
         // end arrives with too little stored
         if ($urandom_range(0, 1))
            add_word(umsr_pkg::CODE_SINGLE, rnd_data(), rnd_byte(), rnd_byte());
      end else begin
         add_word(umsr_pkg::CODE_SYSEX,
                  (flaw == 0) ? rnd_other(umsr_pkg::SYSEX_START) : umsr_pkg::SYSEX_START,
                  rnd_byte(), rnd_byte());
         conts = $urandom_range(0, 4);
         for (int i = 0; i < conts; i++) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
               add_word(umsr_pkg::CODE_SYSEX, rnd_byte(), rnd_byte(), rnd_byte());
            end else if (r < 8) begin
               add_word(umsr_pkg::CODE_SINGLE, rnd_data(), rnd_byte(), rnd_byte());
            end else if (r < 9) begin
               status = {1'b1, 7'(rnd_data())};
               if (status == umsr_pkg::SYSEX_END) status = ~status;
               add_word(umsr_pkg::CODE_SINGLE, status, rnd_byte(), rnd_byte());
            end else begin
               add_word(umsr_pkg::CODE_CC, {umsr_pkg::CC_STATUS, 4'(rnd_byte())},
                        rnd_byte(), rnd_byte());
            end
         end
      end
      closing = (flaw == 1) ? rnd_other(umsr_pkg::SYSEX_END) : umsr_pkg::SYSEX_END;
      case ($urandom_range(0, 3))
         0:       add_word(umsr_pkg::CODE_END1, closing, rnd_byte(), rnd_byte());
         1:       add_word(umsr_pkg::CODE_END2, rnd_byte(), closing, rnd_byte());
         2:       add_word(umsr_pkg::CODE_END3, rnd_byte(), rnd_byte(), closing);
         default: add_word(umsr_pkg::CODE_SINGLE, closing, rnd_byte(), rnd_byte());
      endcase
   endtask

   // Fill the store to one byte short of full, then finish near the limit
   task automatic gen_long_message(input int tail);
      add_word(umsr_pkg::CODE_SYSEX, umsr_pkg::SYSEX_START, rnd_byte(), rnd_byte());
      for (int i = 1; i < umsr_pkg::STORE_BYTES / 3; i++)
         add_word(umsr_pkg::CODE_SYSEX, rnd_byte(), rnd_byte(), rnd_byte());
      case (tail)
         0: add_word(umsr_pkg::CODE_END1, umsr_pkg::SYSEX_END, rnd_byte(), rnd_byte());
         1: add_word(umsr_pkg::CODE_END2, rnd_byte(), umsr_pkg::SYSEX_END, rnd_byte());
         2: add_word(umsr_pkg::CODE_SYSEX, rnd_byte(), rnd_byte(), rnd_byte());
         3: add_word(umsr_pkg::CODE_SINGLE, umsr_pkg::SYSEX_END, rnd_byte(), rnd_byte());
         default: begin
            // top off to full, then try to add more
            add_word(umsr_pkg::CODE_SINGLE, rnd_data(), rnd_byte(), rnd_byte());
            case (tail)
               4: add_word(umsr_pkg::CODE_SINGLE, umsr_pkg::SYSEX_END, rnd_byte(), rnd_byte());
               5: add_word(umsr_pkg::CODE_SINGLE, rnd_data(), rnd_byte(), rnd_byte());
               default: add_word(umsr_pkg::CODE_END1, umsr_pkg::SYSEX_END, rnd_byte(),
                                 rnd_byte());
            endcase
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input umsr_pkg::rsp_type want,
                                  input umsr_pkg::rsp_type got);
      string want_s;
      string got_s;
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         want_s = $sformatf("kind=%0d data=%02h num=%02h val=%02h last=%0b", want.kind,
                            want.data_byte, want.controller_number,
                            want.controller_value, want.last);
         got_s  = $sformatf("kind=%0d data=%02h num=%02h val=%02h last=%0b", got.kind,
                            got.data_byte, got.controller_number,
                            got.controller_value, got.last);
         $display("%0t %s: expected %s, got %s", $realtime, what, want_s, got_s);
      end
   endtask

   // Input driver, falling edge
   always @(negedge clock) begin
      packet_item_type head;
      if (!reset) begin
         if (req_valid && !took_req) begin
            // stalled: hold the word
         end else if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (packet_q.size() != 0) begin
            head = packet_q[0];
            if (head.settle && awaited_rsp.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               void'(packet_q.pop_front());
               req_data  <= head.word;
               req_valid <= 1'b1;
               send_gap = pick_idle(send_quiet);
            end
         end else begin
            req_valid <= 1'b0;
         end

         // Output back-pressure
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_idle(stall_quiet);
         end
      end
   end

   // Prediction and checking, rising edge
   always @(posedge clock) begin
      umsr_pkg::rsp_type got;
      umsr_pkg::rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         took_req <= !reset && req_valid && !req_stall;
         if (!reset) begin
            if (req_valid && !req_stall) predict_packet(req_data);
            if (rsp_valid && !rsp_stall) begin
               got = rsp_data;
               if (awaited_rsp.size() == 0) begin
                  report_mismatch("unexpected word", '0, got);
               end else begin
                  want = awaited_rsp.pop_front();
                  if (got.kind != want.kind || got.data_byte != want.data_byte ||
                      got.controller_number != want.controller_number ||
                      got.controller_value != want.controller_value ||
                      got.last != want.last)
                     report_mismatch("mismatch", want, got);
               end
            end
         end
      end
   end

   initial begin
      int r;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      took_req    = 1'b0;
      cycle_count = 0;
      fail_count  = 0;
      send_gap    = 0;
      send_quiet  = 0;
      stall_left  = 0;
      stall_quiet = 0;
      settle_next = 1'b0;
      live_words  = 0;
      long_count  = 0;
      msg_fill    = 0;

      // Directed: control change, ignored words, each end form, framing faults
      add_word(umsr_pkg::CODE_CC, {umsr_pkg::CC_STATUS, 4'h5}, 8'hFF, 8'h80);
      add_word(umsr_pkg::CODE_CC, 8'h90, 8'h12, 8'h34);
      add_word(umsr_pkg::CODE_END1, umsr_pkg::SYSEX_END, 8'h00, 8'h00);
      add_word(umsr_pkg::CODE_SYSEX, umsr_pkg::SYSEX_START, 8'h01, 8'h02);
      add_word(umsr_pkg::CODE_SINGLE, 8'h7F, 8'h00, 8'h00);
      add_word(umsr_pkg::CODE_SINGLE, 8'h80, 8'hFF, 8'hFF);
      add_word(umsr_pkg::CODE_END3, 8'h03, 8'h04, umsr_pkg::SYSEX_END);
      add_word(umsr_pkg::CODE_SYSEX, umsr_pkg::SYSEX_START, 8'h00, 8'hFF);
      add_word(umsr_pkg::CODE_END1, umsr_pkg::SYSEX_END, 8'hFF, 8'hFF);
      add_word(umsr_pkg::CODE_SYSEX, umsr_pkg::SYSEX_START, 8'h10, 8'h20);
      add_word(umsr_pkg::CODE_END2, 8'h30, umsr_pkg::SYSEX_END, 8'h00);
      add_word(umsr_pkg::CODE_SYSEX, 8'h41, 8'h42, 8'h43);
      add_word(umsr_pkg::CODE_END1, umsr_pkg::SYSEX_END, 8'h00, 8'h00);
      add_word(umsr_pkg::CODE_SYSEX, 8'h00, 8'hFF, 8'h00);
      add_word(umsr_pkg::CODE_SINGLE, umsr_pkg::SYSEX_END, 8'h00, 8'h00);
      add_word(umsr_pkg::CODE_SYSEX, umsr_pkg::SYSEX_START, 8'h01, 8'h02);
      add_word(umsr_pkg::CODE_END2, 8'h03, 8'h04, 8'h00);
      for (int c = 0; c < 16; c++)
         if (!is_live_code(4'(c))) add_word(4'(c), rnd_byte(), rnd_byte(), rnd_byte());

      // Random: mostly well-formed messages, some faults, passthrough and noise
      settle_next = 1'b1;
      live_words  = 0;
      while (live_words < RANDOM_WORDS) begin
         if ($urandom_range(0, 29) == 0) settle_next = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 8) begin
            gen_long_message(long_count % LONG_TAILS);
            long_count++;
         end else if (r < 55) begin
            gen_message(1'b0);
         end else if (r < 70) begin
            gen_message(1'b1);
         end else if (r < 82) begin
            add_word(umsr_pkg::CODE_CC, {umsr_pkg::CC_STATUS, 4'(rnd_byte())},
                     rnd_byte(), rnd_byte());
         end else if (r < 86) begin
            add_word(umsr_pkg::CODE_CC, rnd_other({umsr_pkg::CC_STATUS, 4'h0}),
                     rnd_byte(), rnd_byte());
         end else begin
            repeat ($urandom_range(1, 3))
               add_word(4'(rnd_byte()), rnd_byte(), rnd_byte(), rnd_byte());
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for all input to go in and all results to come out
      while (packet_q.size() != 0 || req_valid) @(posedge clock);
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_TIME) @(posedge clock);

      if (fail_count == 0 && awaited_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
